/* rtl/tle_pkg.sv */
// ----------------------------------------------------------------------------
// tle_pkg: shared constants for the terminal line editor
// Sizes, derived widths and the key codes the editor decodes.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int LINE_BYTES = 128;
  localparam int HIST_DEPTH = 8;
  localparam int IDX_W      = $clog2(LINE_BYTES);
  localparam int SLOT_W     = $clog2(HIST_DEPTH);
  localparam int HADDR_W    = SLOT_W + IDX_W;
  localparam int HIST_BYTES = HIST_DEPTH * LINE_BYTES;

  // longest line the buffer holds
  localparam logic [IDX_W-1:0] LEN_LIMIT = IDX_W'(LINE_BYTES - 1);

  localparam logic [7:0] K_HOME  = 8'h01;
  localparam logic [7:0] K_LEFT  = 8'h02;
  localparam logic [7:0] K_EOT   = 8'h04;
  localparam logic [7:0] K_END   = 8'h05;
  localparam logic [7:0] K_RIGHT = 8'h06;
  localparam logic [7:0] K_BS    = 8'h08;
  localparam logic [7:0] K_LF    = 8'h0a;
  localparam logic [7:0] K_KEOL  = 8'h0b;
  localparam logic [7:0] K_HDOWN = 8'h0e;
  localparam logic [7:0] K_HUP   = 8'h10;
  localparam logic [7:0] K_KLINE = 8'h15;
  localparam logic [7:0] K_ESC   = 8'h1b;
  localparam logic [7:0] K_DEL   = 8'h7f;
  localparam logic [7:0] K_SPACE = 8'h20;
  localparam logic [7:0] K_TILDE = 8'h7e;
  localparam logic [7:0] K_LBRK  = 8'h5b;
  localparam logic [7:0] K_A     = 8'h41;
  localparam logic [7:0] K_B     = 8'h42;
  localparam logic [7:0] K_C     = 8'h43;
  localparam logic [7:0] K_D     = 8'h44;
  localparam logic [7:0] K_1     = 8'h31;
  localparam logic [7:0] K_3     = 8'h33;
  localparam logic [7:0] K_4     = 8'h34;
  localparam logic [7:0] K_7     = 8'h37;
  localparam logic [7:0] K_8     = 8'h38;
  localparam logic [7:0] K_9     = 8'h39;

  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_START = 2'd1;
  localparam logic [1:0] ESC_CSI   = 2'd2;
  localparam logic [1:0] ESC_NUM   = 2'd3;

endpackage

/* rtl/tle_ram.sv */
// ----------------------------------------------------------------------------
// tle_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tle_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/terminal_line_editor.sv */
// ----------------------------------------------------------------------------
// terminal_line_editor: line editor with cursor, escape decoding and history
// Edits a line buffer from key beats, recalls and stores lines in a ring.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in_     | input     | in_valid / in_ready  | cmd, key_byte, read_index
//  out_    | output    | out_valid / out_ready| echo, flags, length, cursor, data
//  cfg_    | input     | cfg_valid / cfg_ready| raw_mode
//
//  Simple keys go straight to the result; reads pass ST_RD first. Inserting
//  inside the line shifts the bytes from the cursor up, then writes the key;
//  a delete shifts the bytes above the position down, and history recall or
//  store copies the line, one byte per cycle through the single write port
//  of the target memory.
//  One beat is in work at a time; a finished result sits in the output
//  register so the next beat is taken while it waits for out_ready.
//  rst_n is synchronous; memories are not cleared (only written bytes are read).
//
module terminal_line_editor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_key_byte,
  input  logic [6:0] in_read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_echo_valid,
  output logic [7:0] out_echo_char,
  output logic       out_bell,
  output logic       out_redraw,
  output logic       out_line_done,
  output logic       out_end_of_input,
  output logic [6:0] out_line_length,
  output logic [6:0] out_cursor_pos,
  output logic [7:0] out_read_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_raw_mode
);

  localparam int IW = tle_pkg::IDX_W;
  localparam int SW = tle_pkg::SLOT_W;
  localparam int HW = tle_pkg::HADDR_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_SHR, ST_INSW, ST_SHL, ST_H2L, ST_L2H, ST_FIN
  } state_t;

  state_t          state_r, state_nxt;
  logic [IW-1:0]   len_r, len_nxt, cur_r, cur_nxt;
  logic [1:0]      esc_r, esc_nxt;
  logic [7:0]      dig_r, dig_nxt;
  logic            clr_r, clr_nxt;
  logic            raw_r;
  logic [IW-1:0]   hlen_r [tle_pkg::HIST_DEPTH];
  logic [IW-1:0]   hlen_nxt [tle_pkg::HIST_DEPTH];
  logic [tle_pkg::HIST_DEPTH-1:0] hval_r, hval_nxt;
  logic [SW-1:0]   head_r, head_nxt, browse_r, browse_nxt;
  // copy/shift sequencer
  logic [IW-1:0]   j_r, j_nxt, e_r, e_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic [7:0]      ch_r, ch_nxt;
  logic            rdok_r, rdok_nxt;
  // pending result flags
  logic            echo_v_r, echo_v_nxt, bell_r, bell_nxt, redraw_r, redraw_nxt;
  logic            done_r, done_nxt, eoi_r, eoi_nxt;
  logic [7:0]      echo_c_r, echo_c_nxt, rd_r, rd_nxt;
  // output register
  logic            out_valid_r;
  logic            out_echo_valid_r, out_bell_r, out_redraw_r, out_done_r, out_eoi_r;
  logic [7:0]      out_echo_char_r, out_read_data_r;
  logic [IW-1:0]   out_len_r, out_cur_r;
  logic            out_load;

  // memory ports
  logic            l_we, h_we;
  logic [IW-1:0]   l_waddr, l_raddr;
  logic [HW-1:0]   h_waddr, h_raddr;
  logic [7:0]      l_wdata, h_wdata, l_rdata, h_rdata;

  tle_ram #(.DEPTH(tle_pkg::LINE_BYTES), .WIDTH(8)) u_line (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  tle_ram #(.DEPTH(tle_pkg::HIST_BYTES), .WIDTH(8)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    logic [IW-1:0] l, k, oldl, dpos;
    logic [7:0]    c;
    logic          del_req, rec_req, str_req;
    logic [SW-1:0] rs, s;

    state_nxt  = state_r;
    len_nxt    = len_r;
    cur_nxt    = cur_r;
    esc_nxt    = esc_r;
    dig_nxt    = dig_r;
    clr_nxt    = clr_r;
    hlen_nxt   = hlen_r;
    hval_nxt   = hval_r;
    head_nxt   = head_r;
    browse_nxt = browse_r;
    j_nxt      = j_r;
    e_nxt      = e_r;
    slot_nxt   = slot_r;
    ch_nxt     = ch_r;
    rdok_nxt   = rdok_r;
    echo_v_nxt = echo_v_r;
    echo_c_nxt = echo_c_r;
    bell_nxt   = bell_r;
    redraw_nxt = redraw_r;
    done_nxt   = done_r;
    eoi_nxt    = eoi_r;
    rd_nxt     = rd_r;
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = '0;
    h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;
    l = len_r; k = cur_r; oldl = len_r; dpos = '0;
    c = in_key_byte;
    del_req = 1'b0; rec_req = 1'b0; str_req = 1'b0;
    rs = '0; s = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          echo_v_nxt = 1'b0; echo_c_nxt = '0; bell_nxt = 1'b0; redraw_nxt = 1'b0;
          done_nxt = 1'b0; eoi_nxt = 1'b0; rd_nxt = '0;
          state_nxt = ST_FIN;
          if (in_cmd) begin
            l_raddr   = in_read_index;
            rdok_nxt  = (in_read_index < len_r);
            state_nxt = ST_RD;
          end else begin
            if (clr_r) begin
              l = '0; k = '0;
            end
            clr_nxt = 1'b0;
            if (raw_r) begin
              if (c == tle_pkg::K_LF) begin
                done_nxt = 1'b1; clr_nxt = 1'b1;
              end else if (c == tle_pkg::K_EOT && l == '0) begin
                eoi_nxt = 1'b1;
              end else if ((c inside {[tle_pkg::K_SPACE:tle_pkg::K_TILDE]})
                           && l < tle_pkg::LEN_LIMIT) begin
                l_we = 1'b1; l_waddr = l; l_wdata = c;
                l = l + 1'b1;
              end
            end else if (esc_r != tle_pkg::ESC_NONE) begin
              redraw_nxt = 1'b1;
              if (esc_r == tle_pkg::ESC_START) begin
                esc_nxt = (c == tle_pkg::K_LBRK) ? tle_pkg::ESC_CSI : tle_pkg::ESC_NONE;
                redraw_nxt = 1'b0;
              end else if (esc_r == tle_pkg::ESC_CSI) begin
                esc_nxt = tle_pkg::ESC_NONE;
                if (c == tle_pkg::K_A) begin
                  s = browse_r - 1'b1;
                  if (!hval_r[s]) bell_nxt = 1'b1;
                  else begin
                    rec_req = 1'b1; rs = s;
                  end
                end else if (c == tle_pkg::K_B) begin
                  s = browse_r + 1'b1;
                  if (!hval_r[browse_r]) bell_nxt = 1'b1;
                  else if (!hval_r[s]) begin
                    l = '0; k = '0; browse_nxt = head_r;
                  end else begin
                    rec_req = 1'b1; rs = s;
                  end
                end else if (c == tle_pkg::K_C) begin
                  if (k < l) k = k + 1'b1;
                end else if (c == tle_pkg::K_D) begin
                  if (k != '0) k = k - 1'b1;
                end else begin
                  if (c inside {[tle_pkg::K_1:tle_pkg::K_9]}) begin
                    esc_nxt = tle_pkg::ESC_NUM; dig_nxt = c;
                  end
                  redraw_nxt = 1'b0;
                end
              end else begin
                esc_nxt = tle_pkg::ESC_NONE;
                if (c == tle_pkg::K_TILDE) begin
                  if (dig_r inside {tle_pkg::K_1, tle_pkg::K_7}) k = '0;
                  else if (dig_r == tle_pkg::K_3) begin
                    del_req = 1'b1; dpos = k;
                  end else if (dig_r inside {tle_pkg::K_4, tle_pkg::K_8}) k = l;
                  else redraw_nxt = 1'b0;
                end
              end
            end else if (c inside {[tle_pkg::K_SPACE:tle_pkg::K_TILDE]}) begin
              if (l < tle_pkg::LEN_LIMIT) begin
                echo_v_nxt = 1'b1; echo_c_nxt = c;
                if (k < l) begin
                  // open a gap at the cursor, top byte first
                  redraw_nxt = 1'b1;
                  l_raddr = l - 1'b1;
                  j_nxt = l - 1'b1; e_nxt = k; ch_nxt = c;
                  state_nxt = ST_SHR;
                  l = l + 1'b1; k = k + 1'b1;
                end else begin
                  l_we = 1'b1; l_waddr = k; l_wdata = c;
                  k = k + 1'b1; l = k;
                end
              end else begin
                redraw_nxt = 1'b1;
              end
            end else if (c == tle_pkg::K_LF) begin
              echo_v_nxt = 1'b1; echo_c_nxt = tle_pkg::K_LF;
              redraw_nxt = 1'b1; clr_nxt = 1'b1; done_nxt = 1'b1;
              str_req = (l != '0);
            end else if (c == tle_pkg::K_EOT && l == '0) begin
              echo_v_nxt = 1'b1; echo_c_nxt = tle_pkg::K_LF;
              redraw_nxt = 1'b1; eoi_nxt = 1'b1;
            end else begin
              redraw_nxt = 1'b1;
              case (c)
                tle_pkg::K_HOME:  k = '0;
                tle_pkg::K_LEFT:  if (k != '0) k = k - 1'b1;
                tle_pkg::K_END:   k = l;
                tle_pkg::K_RIGHT: if (k < l) k = k + 1'b1;
                tle_pkg::K_BS, tle_pkg::K_DEL: begin
                  if (k != '0) begin
                    k = k - 1'b1; del_req = 1'b1; dpos = k;
                  end
                end
                tle_pkg::K_KEOL:  l = k;
                tle_pkg::K_HDOWN: begin
                  s = browse_r + 1'b1;
                  if (!hval_r[browse_r]) bell_nxt = 1'b1;
                  else if (!hval_r[s]) begin
                    l = '0; k = '0; browse_nxt = head_r;
                  end else begin
                    rec_req = 1'b1; rs = s;
                  end
                end
                tle_pkg::K_HUP: begin
                  s = browse_r - 1'b1;
                  if (!hval_r[s]) bell_nxt = 1'b1;
                  else begin
                    rec_req = 1'b1; rs = s;
                  end
                end
                tle_pkg::K_KLINE: begin
                  l = '0; k = '0;
                end
                tle_pkg::K_ESC: begin
                  esc_nxt = tle_pkg::ESC_START; redraw_nxt = 1'b0;
                end
                default: redraw_nxt = 1'b0;
              endcase
            end

            // delete one byte at dpos, closing the gap from below
            if (del_req && dpos < l) begin
              oldl = l;
              l = l - 1'b1;
              if (dpos + 1'b1 < oldl) begin
                l_raddr = dpos + 1'b1;
                j_nxt = dpos; e_nxt = oldl - 2'd2;
                state_nxt = ST_SHL;
              end
            end
            // recall a history slot into the line
            if (rec_req) begin
              browse_nxt = rs;
              l = hlen_r[rs]; k = hlen_r[rs];
              if (hlen_r[rs] != '0) begin
                h_raddr = {rs, IW'(0)};
                j_nxt = '0; e_nxt = hlen_r[rs] - 1'b1; slot_nxt = rs;
                state_nxt = ST_H2L;
              end
            end
            // store the completed line at the head slot
            if (str_req) begin
              hlen_nxt[head_r] = l;
              hval_nxt[head_r] = 1'b1;
              s = head_r + 1'b1;
              head_nxt = s; browse_nxt = s;
              hval_nxt[s] = 1'b0; hlen_nxt[s] = '0;
              l_raddr = '0;
              j_nxt = '0; e_nxt = l - 1'b1; slot_nxt = head_r;
              state_nxt = ST_L2H;
            end
            len_nxt = l;
            cur_nxt = k;
          end
        end
      end
      ST_RD: begin
        rd_nxt    = rdok_r ? l_rdata : 8'h00;
        state_nxt = ST_FIN;
      end
      ST_SHR: begin
        l_we = 1'b1; l_waddr = j_r + 1'b1; l_wdata = l_rdata;
        if (j_r == e_r) state_nxt = ST_INSW;
        else begin
          j_nxt = j_r - 1'b1; l_raddr = j_r - 1'b1;
        end
      end
      ST_INSW: begin
        l_we = 1'b1; l_waddr = e_r; l_wdata = ch_r;
        state_nxt = ST_FIN;
      end
      ST_SHL: begin
        l_we = 1'b1; l_waddr = j_r; l_wdata = l_rdata;
        l_raddr = j_r + 2'd2;
        j_nxt = j_r + 1'b1;
        if (j_r == e_r) state_nxt = ST_FIN;
      end
      ST_H2L: begin
        l_we = 1'b1; l_waddr = j_r; l_wdata = h_rdata;
        h_raddr = {slot_r, IW'(j_r + 1'b1)};
        j_nxt = j_r + 1'b1;
        if (j_r == e_r) state_nxt = ST_FIN;
      end
      ST_L2H: begin
        h_we = 1'b1; h_waddr = {slot_r, j_r}; h_wdata = l_rdata;
        l_raddr = j_r + 1'b1;
        j_nxt = j_r + 1'b1;
        if (j_r == e_r) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      len_r    <= '0;
      cur_r    <= '0;
      esc_r    <= tle_pkg::ESC_NONE;
      dig_r    <= '0;
      clr_r    <= 1'b1;
      raw_r    <= 1'b0;
      hval_r   <= '0;
      head_r   <= '0;
      browse_r <= '0;
      out_valid_r      <= 1'b0;
      out_echo_valid_r <= 1'b0;
      out_echo_char_r  <= '0;
      out_bell_r       <= 1'b0;
      out_redraw_r     <= 1'b0;
      out_done_r       <= 1'b0;
      out_eoi_r        <= 1'b0;
      out_len_r        <= '0;
      out_cur_r        <= '0;
      out_read_data_r  <= '0;
      for (int i = 0; i < tle_pkg::HIST_DEPTH; i++) begin
        hlen_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      cur_r    <= cur_nxt;
      esc_r    <= esc_nxt;
      dig_r    <= dig_nxt;
      clr_r    <= clr_nxt;
      hval_r   <= hval_nxt;
      head_r   <= head_nxt;
      browse_r <= browse_nxt;
      hlen_r   <= hlen_nxt;
      if (cfg_valid) raw_r <= cfg_raw_mode;
      if (out_load) begin
        out_valid_r      <= 1'b1;
        out_echo_valid_r <= echo_v_r;
        out_echo_char_r  <= echo_c_r;
        out_bell_r       <= bell_r;
        out_redraw_r     <= redraw_r;
        out_done_r       <= done_r;
        out_eoi_r        <= eoi_r;
        out_len_r        <= len_r;
        out_cur_r        <= cur_r;
        out_read_data_r  <= rd_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sequencer and pending result registers, no reset
  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    e_r      <= e_nxt;
    slot_r   <= slot_nxt;
    ch_r     <= ch_nxt;
    rdok_r   <= rdok_nxt;
    echo_v_r <= echo_v_nxt;
    echo_c_r <= echo_c_nxt;
    bell_r   <= bell_nxt;
    redraw_r <= redraw_nxt;
    done_r   <= done_nxt;
    eoi_r    <= eoi_nxt;
    rd_r     <= rd_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_echo_valid   = out_echo_valid_r;
  assign out_echo_char    = out_echo_char_r;
  assign out_bell         = out_bell_r;
  assign out_redraw       = out_redraw_r;
  assign out_line_done    = out_done_r;
  assign out_end_of_input = out_eoi_r;
  assign out_line_length  = out_len_r;
  assign out_cursor_pos   = out_cur_r;
  assign out_read_data    = out_read_data_r;

  // cursor never passes the end of the line
  a_cur_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= len_r) else $error("cursor beyond line length");

  // the head slot of the ring is always free
  a_head_free: assert property (@(posedge clk) disable iff (!rst_n)
    !hval_r[head_r]) else $error("history head slot marked valid");

  // insert shift walks down toward the cursor, never past it
  a_shr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHR) |-> (j_r >= e_r)) else $error("insert shift overran");

endmodule
